// ===== hw/rtl/tpcc_pkg.sv =====
`default_nettype none
package tpcc_pkg;

  localparam int COORD_BITS_DEF = 16;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam int CENTER_BITS = 32;

endpackage
`default_nettype wire

// ===== hw/rtl/tpcc_div_cell.sv =====
`default_nettype none
module tpcc_div_cell #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire logic [DW-1:0] in_rem,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [NW-1:0] in_quo,
  input  wire logic [DW-1:0] in_dmag,
  input  wire logic [SW-1:0] in_side,
  output logic               out_vld,
  output logic [DW-1:0]      out_rem,
  output logic [NW-1:0]      out_num,
  output logic [NW-1:0]      out_quo,
  output logic [DW-1:0]      out_dmag,
  output logic [SW-1:0]      out_side
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;
  logic          vld_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] num_r, quo_r;
  logic [DW-1:0] dmag_r;
  logic [SW-1:0] side_r;

  // one restoring step: bring down the next numerator bit
  always_comb begin
    trial   = {in_rem, in_num[NW-1]};
    diff    = trial - {1'b0, in_dmag};
    take    = (trial >= {1'b0, in_dmag});
    rem_nxt = take ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    num_r  <= {in_num[NW-2:0], 1'b0};
    quo_r  <= {in_quo[NW-2:0], take};
    dmag_r <= in_dmag;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_rem  = rem_r;
  assign out_num  = num_r;
  assign out_quo  = quo_r;
  assign out_dmag = dmag_r;
  assign out_side = side_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tpcc_divider.sv =====
`default_nettype none
module tpcc_divider #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] in_nmag,
  input  wire logic [DW-1:0] in_dmag,
  input  wire logic [SW-1:0] in_side,
  output logic               out_vld,
  output logic [NW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);

  logic [NW:0]   vld_w;
  logic [DW-1:0] rem_w  [NW+1];
  logic [NW-1:0] num_w  [NW+1];
  logic [NW-1:0] quo_w  [NW+1];
  logic [DW-1:0] dmag_w [NW+1];
  logic [SW-1:0] side_w [NW+1];

  assign vld_w[0]  = in_vld;
  assign rem_w[0]  = '0;
  assign num_w[0]  = in_nmag;
  assign quo_w[0]  = '0;
  assign dmag_w[0] = in_dmag;
  assign side_w[0] = in_side;

  // one quotient bit per cell, most significant first
  for (genvar i = 0; i < NW; i++) begin : g_cell
    tpcc_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (vld_w[i]),
      .in_rem   (rem_w[i]),
      .in_num   (num_w[i]),
      .in_quo   (quo_w[i]),
      .in_dmag  (dmag_w[i]),
      .in_side  (side_w[i]),
      .out_vld  (vld_w[i+1]),
      .out_rem  (rem_w[i+1]),
      .out_num  (num_w[i+1]),
      .out_quo  (quo_w[i+1]),
      .out_dmag (dmag_w[i+1]),
      .out_side (side_w[i+1])
    );
  end

  assign out_vld  = vld_w[NW];
  assign out_quo  = quo_w[NW];
  assign out_side = side_w[NW];

endmodule
`default_nettype wire

// ===== hw/rtl/three_point_circle_center_unit.sv =====
`default_nettype none
// Center of the circle through three points.
//
// Input: one word of three points (first, middle, last), each coordinate a
// signed COORD_BITS-bit value, taken at a rising edge with start high and busy
// low. busy is always low: a new word is taken in every cycle.
//
// Output: out_valid is high for one cycle with out_center_x, out_center_y
// (signed 32 bits, truncated toward zero, saturated) and out_status
// (ok, degenerate, saturated). The receiver cannot stall; every word is
// delivered exactly once.
//
// Pipeline: two cell chains of restoring dividers, one cell per quotient bit,
// 3*COORD_BITS+3 cells for center_x and COORD_BITS+35 cells for center_y,
// plus eight register stages around them. Throughput: one word per cycle.
//
// Reset (synchronous, rst_n low) clears every valid bit in the pipeline; words
// in flight are dropped and no result appears for them.
module three_point_circle_center_unit #(
  parameter int COORD_BITS = tpcc_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] in_first_x,
  input  wire logic signed [COORD_BITS-1:0] in_first_y,
  input  wire logic signed [COORD_BITS-1:0] in_middle_x,
  input  wire logic signed [COORD_BITS-1:0] in_middle_y,
  input  wire logic signed [COORD_BITS-1:0] in_last_x,
  input  wire logic signed [COORD_BITS-1:0] in_last_y,
  output logic                              out_valid,
  output logic signed [tpcc_pkg::CENTER_BITS-1:0] out_center_x,
  output logic signed [tpcc_pkg::CENTER_BITS-1:0] out_center_y,
  output logic [1:0]                        out_status
);
  import tpcc_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int DFW  = C + 1;           // point differences
  localparam int SQW  = 2 * C;           // one square
  localparam int LW   = 2 * C + 1;       // squared lengths and their differences
  localparam int PW   = DFW + LW;        // d * l products
  localparam int CW   = 2 * DFW;         // cross products
  localparam int NUMW = PW + 1;          // center_x numerator
  localparam int DENW = CW + 2;          // twice the cross term
  localparam int EW   = C + 2;           // doubled differences
  localparam int MW   = CENTER_BITS + EW; // cx * 2e
  localparam int N2W  = MW + 1;          // center_y numerator
  localparam int QX1  = (NUMW > CENTER_BITS + 1) ? NUMW : CENTER_BITS + 1;
  localparam int QX2  = (N2W > CENTER_BITS + 1) ? N2W : CENTER_BITS + 1;
  localparam int LAT  = 8 + NUMW + N2W;

  typedef struct packed {
    logic                  neg;
    logic                  degen;
    logic signed [LW-1:0]  a;
    logic signed [DFW-1:0] e;
    logic signed [DFW-1:0] dy;
  } side1_t;

  typedef struct packed {
    logic                          neg;
    logic                          degen;
    logic                          sat;
    logic signed [CENTER_BITS-1:0] cx;
  } side2_t;

  // stage 1: input registers
  logic                 s1_vld_r;
  logic signed [C-1:0]  s1_x0_r, s1_y0_r, s1_x1_r, s1_y1_r, s1_x2_r, s1_y2_r;

  // stage 2: differences and squared lengths
  logic                   s2_vld_r;
  logic signed [DFW-1:0]  s2_d0x_r, s2_d0y_r, s2_d1x_r, s2_d1y_r;
  logic signed [LW-1:0]   s2_dl01_r, s2_dl12_r;
  logic signed [DFW-1:0]  d0x_nxt, d0y_nxt, d1x_nxt, d1y_nxt;
  logic signed [SQW-1:0]  sx0, sy0, sx1, sy1, sx2, sy2;
  logic signed [LW-1:0]   l0, l1, l2;

  // stage 3: products
  logic                   s3_vld_r;
  logic signed [PW-1:0]   s3_p1_r, s3_p2_r;
  logic signed [CW-1:0]   s3_c1_r, s3_c2_r;
  logic signed [LW-1:0]   s3_dl01_r, s3_dl12_r;
  logic signed [DFW-1:0]  s3_d0x_r, s3_d0y_r, s3_d1x_r, s3_d1y_r;

  // stage 4: numerator, denominator, row choice
  logic                   s4_vld_r;
  logic signed [NUMW-1:0] s4_num_r;
  logic signed [DENW-1:0] s4_den_r;
  logic signed [LW-1:0]   s4_a_r;
  logic signed [DFW-1:0]  s4_e_r, s4_dy_r;
  logic signed [DENW-1:0] den_diff;

  // first divider
  logic [NUMW-1:0]        div1_nmag;
  logic [DENW-1:0]        div1_dmag;
  side1_t                 div1_side_in, div1_side_out;
  logic                   div1_vld;
  logic [NUMW-1:0]        div1_quo;
  logic [QX1-1:0]         q1x;
  logic                   sat1_nxt;
  logic signed [CENTER_BITS-1:0] cx_nxt;

  // stage 6: clamped center_x
  logic                   s6_vld_r, s6_sat_r, s6_degen_r;
  logic signed [CENTER_BITS-1:0] s6_cx_r;
  logic signed [LW-1:0]   s6_a_r;
  logic signed [DFW-1:0]  s6_e_r, s6_dy_r;
  logic signed [EW-1:0]   e2;

  // stage 7: cx * 2e
  logic                   s7_vld_r, s7_sat_r, s7_degen_r;
  logic signed [CENTER_BITS-1:0] s7_cx_r;
  logic signed [MW-1:0]   s7_prod_r;
  logic signed [LW-1:0]   s7_a_r;
  logic signed [DFW-1:0]  s7_dy_r;

  // stage 8: center_y numerator
  logic                   s8_vld_r, s8_sat_r, s8_degen_r;
  logic signed [CENTER_BITS-1:0] s8_cx_r;
  logic signed [N2W-1:0]  s8_n2_r;
  logic signed [DFW-1:0]  s8_dy_r;
  logic signed [EW-1:0]   dy2;

  // second divider
  logic [N2W-1:0]         div2_nmag;
  logic [EW-1:0]          div2_dmag;
  side2_t                 div2_side_in, div2_side_out;
  logic                   div2_vld;
  logic [N2W-1:0]         div2_quo;
  logic [QX2-1:0]         q2x;
  logic                   sat2;
  logic signed [CENTER_BITS-1:0] cy_clamp;

  // stage 9: result registers
  logic                   out_vld_r;
  logic signed [CENTER_BITS-1:0] out_cx_r, out_cy_r, out_cx_nxt, out_cy_nxt;
  logic [1:0]             out_st_r, out_st_nxt;

  assign busy = 1'b0;

  // ---------------- valid chain outside the dividers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= start & ~busy;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s6_vld_r  <= div1_vld;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      out_vld_r <= div2_vld;
    end
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    s1_x0_r <= in_first_x;
    s1_y0_r <= in_first_y;
    s1_x1_r <= in_middle_x;
    s1_y1_r <= in_middle_y;
    s1_x2_r <= in_last_x;
    s1_y2_r <= in_last_y;
  end

  // ---------------- stage 2 ----------------
  always_comb begin
    d0x_nxt = DFW'(s1_x0_r) - DFW'(s1_x1_r);
    d0y_nxt = DFW'(s1_y0_r) - DFW'(s1_y1_r);
    d1x_nxt = DFW'(s1_x1_r) - DFW'(s1_x2_r);
    d1y_nxt = DFW'(s1_y1_r) - DFW'(s1_y2_r);
    sx0 = SQW'(s1_x0_r) * SQW'(s1_x0_r);
    sy0 = SQW'(s1_y0_r) * SQW'(s1_y0_r);
    sx1 = SQW'(s1_x1_r) * SQW'(s1_x1_r);
    sy1 = SQW'(s1_y1_r) * SQW'(s1_y1_r);
    sx2 = SQW'(s1_x2_r) * SQW'(s1_x2_r);
    sy2 = SQW'(s1_y2_r) * SQW'(s1_y2_r);
    l0  = LW'(sx0) + LW'(sy0);
    l1  = LW'(sx1) + LW'(sy1);
    l2  = LW'(sx2) + LW'(sy2);
  end

  always_ff @(posedge clk) begin
    s2_d0x_r  <= d0x_nxt;
    s2_d0y_r  <= d0y_nxt;
    s2_d1x_r  <= d1x_nxt;
    s2_d1y_r  <= d1y_nxt;
    s2_dl01_r <= l0 - l1;
    s2_dl12_r <= l1 - l2;
  end

  // ---------------- stage 3 ----------------
  always_ff @(posedge clk) begin
    s3_p1_r   <= PW'(s2_d1y_r) * PW'(s2_dl01_r);
    s3_p2_r   <= PW'(s2_d0y_r) * PW'(s2_dl12_r);
    s3_c1_r   <= CW'(s2_d0x_r) * CW'(s2_d1y_r);
    s3_c2_r   <= CW'(s2_d1x_r) * CW'(s2_d0y_r);
    s3_dl01_r <= s2_dl01_r;
    s3_dl12_r <= s2_dl12_r;
    s3_d0x_r  <= s2_d0x_r;
    s3_d0y_r  <= s2_d0y_r;
    s3_d1x_r  <= s2_d1x_r;
    s3_d1y_r  <= s2_d1y_r;
  end

  // ---------------- stage 4 ----------------
  assign den_diff = DENW'(s3_c1_r) - DENW'(s3_c2_r);

  always_ff @(posedge clk) begin
    s4_num_r <= NUMW'(s3_p1_r) - NUMW'(s3_p2_r);
    s4_den_r <= den_diff <<< 1;
    // first row unless its y difference is zero
    if (s3_d0y_r != '0) begin
      s4_a_r  <= s3_dl01_r;
      s4_e_r  <= s3_d0x_r;
      s4_dy_r <= s3_d0y_r;
    end else begin
      s4_a_r  <= s3_dl12_r;
      s4_e_r  <= s3_d1x_r;
      s4_dy_r <= s3_d1y_r;
    end
  end

  // ---------------- center_x divider ----------------
  always_comb begin
    div1_nmag = s4_num_r[NUMW-1] ? NUMW'(-s4_num_r) : NUMW'(s4_num_r);
    if (s4_den_r == '0) begin
      div1_dmag = DENW'(1);
    end else begin
      div1_dmag = s4_den_r[DENW-1] ? DENW'(-s4_den_r) : DENW'(s4_den_r);
    end
    div1_side_in.neg   = s4_num_r[NUMW-1] ^ s4_den_r[DENW-1];
    div1_side_in.degen = (s4_den_r == '0);
    div1_side_in.a     = s4_a_r;
    div1_side_in.e     = s4_e_r;
    div1_side_in.dy    = s4_dy_r;
  end

  tpcc_divider #(.NW(NUMW), .DW(DENW), .SW($bits(side1_t))) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_nmag  (div1_nmag),
    .in_dmag  (div1_dmag),
    .in_side  (div1_side_in),
    .out_vld  (div1_vld),
    .out_quo  (div1_quo),
    .out_side (div1_side_out)
  );

  // clamp the sign-magnitude quotient to 32 bits
  always_comb begin
    q1x = QX1'(div1_quo);
    if (div1_side_out.neg) begin
      sat1_nxt = (|q1x[QX1-1:CENTER_BITS]) ||
                 (q1x[CENTER_BITS-1] && (|q1x[CENTER_BITS-2:0]));
      cx_nxt   = sat1_nxt ? {1'b1, {(CENTER_BITS-1){1'b0}}}
                          : -$signed(q1x[CENTER_BITS-1:0]);
    end else begin
      sat1_nxt = |q1x[QX1-1:CENTER_BITS-1];
      cx_nxt   = sat1_nxt ? {1'b0, {(CENTER_BITS-1){1'b1}}}
                          : $signed(q1x[CENTER_BITS-1:0]);
    end
  end

  // ---------------- stage 6 ----------------
  always_ff @(posedge clk) begin
    s6_cx_r    <= cx_nxt;
    s6_sat_r   <= sat1_nxt;
    s6_degen_r <= div1_side_out.degen;
    s6_a_r     <= div1_side_out.a;
    s6_e_r     <= div1_side_out.e;
    s6_dy_r    <= div1_side_out.dy;
  end

  // ---------------- stage 7 ----------------
  assign e2 = EW'(s6_e_r) <<< 1;

  always_ff @(posedge clk) begin
    s7_prod_r  <= MW'(s6_cx_r) * MW'(e2);
    s7_cx_r    <= s6_cx_r;
    s7_sat_r   <= s6_sat_r;
    s7_degen_r <= s6_degen_r;
    s7_a_r     <= s6_a_r;
    s7_dy_r    <= s6_dy_r;
  end

  // ---------------- stage 8 ----------------
  always_ff @(posedge clk) begin
    s8_n2_r    <= N2W'(s7_a_r) - N2W'(s7_prod_r);
    s8_cx_r    <= s7_cx_r;
    s8_sat_r   <= s7_sat_r;
    s8_degen_r <= s7_degen_r;
    s8_dy_r    <= s7_dy_r;
  end

  // ---------------- center_y divider ----------------
  assign dy2 = EW'(s8_dy_r) <<< 1;

  always_comb begin
    div2_nmag = s8_n2_r[N2W-1] ? N2W'(-s8_n2_r) : N2W'(s8_n2_r);
    // the chosen row difference is zero only for degenerate words
    if (dy2 == '0) begin
      div2_dmag = EW'(1);
    end else begin
      div2_dmag = dy2[EW-1] ? EW'(-dy2) : EW'(dy2);
    end
    div2_side_in.neg   = s8_n2_r[N2W-1] ^ dy2[EW-1];
    div2_side_in.degen = s8_degen_r;
    div2_side_in.sat   = s8_sat_r;
    div2_side_in.cx    = s8_cx_r;
  end

  tpcc_divider #(.NW(N2W), .DW(EW), .SW($bits(side2_t))) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s8_vld_r),
    .in_nmag  (div2_nmag),
    .in_dmag  (div2_dmag),
    .in_side  (div2_side_in),
    .out_vld  (div2_vld),
    .out_quo  (div2_quo),
    .out_side (div2_side_out)
  );

  always_comb begin
    q2x = QX2'(div2_quo);
    if (div2_side_out.neg) begin
      sat2     = (|q2x[QX2-1:CENTER_BITS]) ||
                 (q2x[CENTER_BITS-1] && (|q2x[CENTER_BITS-2:0]));
      cy_clamp = sat2 ? {1'b1, {(CENTER_BITS-1){1'b0}}}
                      : -$signed(q2x[CENTER_BITS-1:0]);
    end else begin
      sat2     = |q2x[QX2-1:CENTER_BITS-1];
      cy_clamp = sat2 ? {1'b0, {(CENTER_BITS-1){1'b1}}}
                      : $signed(q2x[CENTER_BITS-1:0]);
    end
    if (div2_side_out.degen) begin
      out_cx_nxt = '0;
      out_cy_nxt = '0;
      out_st_nxt = STATUS_DEGEN;
    end else begin
      out_cx_nxt = div2_side_out.cx;
      out_cy_nxt = cy_clamp;
      out_st_nxt = (div2_side_out.sat || sat2) ? STATUS_SAT : STATUS_OK;
    end
  end

  // ---------------- stage 9 ----------------
  always_ff @(posedge clk) begin
    out_cx_r <= out_cx_nxt;
    out_cy_r <= out_cy_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_valid    = out_vld_r;
  assign out_center_x = out_cx_r;
  assign out_center_y = out_cy_r;
  assign out_status   = out_st_r;

  // ---------------- assertions ----------------
  a_out_has_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result word without a matching start");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_DEGEN) |-> (out_center_x == '0 && out_center_y == '0))
    else $error("degenerate word with nonzero center");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_DEGEN ||
                   out_status == STATUS_SAT))
    else $error("undefined status code");

  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_center_x, out_center_y, out_status}))
    else $error("result word with unknown bits");

endmodule
`default_nettype wire
